/* design/fan_level_hysteresis_control_top_assert.svh */
// ----------------------------------------------------------------------------
// Fan level hysteresis control - assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef FAN_LEVEL_HYSTERESIS_CONTROL_TOP_ASSERT_SVH
`define FAN_LEVEL_HYSTERESIS_CONTROL_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define FLHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication outside reset.
`define FLHC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define FLHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FLHC_ASSERT(label, prop, msg)
`define FLHC_ASSERT_IMPL(label, ante, cons, msg)
`define FLHC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* design/flhc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fan level hysteresis control - package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package flhc_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 8;

    localparam logic [CfgIdxW-1:0] REG_FIRST_THR  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SECOND_THR = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_THIRD_THR  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_RISE_MARGIN = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS = 3'd4;

    localparam logic [7:0] RST_FIRST_THR   = 8'd30;
    localparam logic [7:0] RST_SECOND_THR  = 8'd40;
    localparam logic [7:0] RST_THIRD_THR   = 8'd50;
    localparam logic [5:0] RST_RISE_MARGIN = 6'd5;
    localparam logic [6:0] RST_HOLD_TICKS  = 7'd60;

    localparam logic [7:0] ABSENT_MARK = 8'hff;
    localparam logic [7:0] BAND3_TOP   = 8'hff;

    typedef enum logic [1:0] {
        BAND_0 = 2'd0,
        BAND_1 = 2'd1,
        BAND_2 = 2'd2,
        BAND_3 = 2'd3
    } t_band;

    typedef struct packed {
        logic [7:0] first_threshold;
        logic [7:0] second_threshold;
        logic [7:0] third_threshold;
        logic [5:0] rise_margin;
        logic [6:0] hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic       sensor_absent;
        logic       level_changed;
        logic [1:0] speed_level;
    } t_result;

endpackage
`default_nettype wire

/* design/flhc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fan level hysteresis control - configuration registers
// Write-only register file holding thresholds, margin and hold count.
// ----------------------------------------------------------------------------
module flhc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [flhc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [flhc_pkg::CfgDataW-1:0] i_cfg_wdata,
    output flhc_pkg::t_cfg                     o_cfg
);
    import flhc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FIRST_THR:   n_cfg.first_threshold  = i_cfg_wdata;
                REG_SECOND_THR:  n_cfg.second_threshold = i_cfg_wdata;
                REG_THIRD_THR:   n_cfg.third_threshold  = i_cfg_wdata;
                REG_RISE_MARGIN: n_cfg.rise_margin      = i_cfg_wdata[5:0];
                REG_HOLD_TICKS:  n_cfg.hold_ticks       = i_cfg_wdata[6:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_threshold  <= RST_FIRST_THR;
            r_cfg.second_threshold <= RST_SECOND_THR;
            r_cfg.third_threshold  <= RST_THIRD_THR;
            r_cfg.rise_margin      <= RST_RISE_MARGIN;
            r_cfg.hold_ticks       <= RST_HOLD_TICKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* design/flhc_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fan level hysteresis control - band tracker
// Band state, below-band counter and the per-sample decision logic.
// ----------------------------------------------------------------------------
`include "fan_level_hysteresis_control_top_assert.svh"

module flhc_step (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_temp_raw,
    input  wire flhc_pkg::t_cfg i_cfg,
    output flhc_pkg::t_result o_res
);
    import flhc_pkg::*;

    t_band      r_band;
    t_band      n_band;
    logic       r_chosen;
    logic [6:0] r_below_count;
    logic [6:0] n_below_count;

    logic       absent;
    logic       le_first;
    logic       le_second;
    logic       le_third;
    t_band      pick;
    logic [7:0] band_top;
    logic [8:0] rise_limit;
    logic       go_up;
    logic       below;
    logic [7:0] count_inc;
    logic       hold_hit;
    logic       leave;

    // absent sensor reads as -1: below every threshold, never above a band top
    assign absent    = (i_temp_raw == ABSENT_MARK);
    assign le_first  = absent || (i_temp_raw <= i_cfg.first_threshold);
    assign le_second = absent || (i_temp_raw <= i_cfg.second_threshold);
    assign le_third  = absent || (i_temp_raw <= i_cfg.third_threshold);

    always_comb begin
        if (le_first)       pick = BAND_0;
        else if (le_second) pick = BAND_1;
        else if (le_third)  pick = BAND_2;
        else                pick = BAND_3;
    end

    always_comb begin
        unique case (r_band)
            BAND_0:  begin band_top = i_cfg.first_threshold;  below = 1'b0;      end
            BAND_1:  begin band_top = i_cfg.second_threshold; below = le_first;  end
            BAND_2:  begin band_top = i_cfg.third_threshold;  below = le_second; end
            BAND_3:  begin band_top = BAND3_TOP;              below = le_third;  end
            default: begin band_top = BAND3_TOP;              below = 1'b0;      end
        endcase
    end

    assign rise_limit = {1'b0, band_top} + {3'b000, i_cfg.rise_margin};
    assign go_up      = !absent && ({1'b0, i_temp_raw} > rise_limit);
    assign count_inc  = {1'b0, r_below_count} + 8'd1;
    assign hold_hit   = (count_inc >= {1'b0, i_cfg.hold_ticks});
    assign leave      = go_up || (below && hold_hit);

    always_comb begin
        n_band        = r_band;
        n_below_count = r_below_count;
        if (!r_chosen || leave) begin
            n_band        = pick;
            n_below_count = '0;
        end else if (below) begin
            n_below_count = count_inc[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band        <= BAND_0;
            r_chosen      <= 1'b0;
            r_below_count <= '0;
        end else if (i_fire) begin
            r_band        <= n_band;
            r_chosen      <= 1'b1;
            r_below_count <= n_below_count;
        end
    end

    assign o_res.speed_level   = n_band;
    assign o_res.level_changed = !r_chosen || (n_band != r_band);
    assign o_res.sensor_absent = absent;

    `FLHC_ASSERT(a_count_range, r_below_count != 7'h7f, "below count out of range")
    `FLHC_ASSERT_IMPL(a_unpicked_idle, !r_chosen, (r_band == BAND_0) && (r_below_count == 7'd0), "state moved before first pick")
    `FLHC_ASSERT_NEXT(a_change_clears, i_fire && r_chosen && (n_band != r_band), r_below_count == 7'd0, "count kept across band change")
    `FLHC_ASSERT_NEXT(a_hold_below, i_fire && r_chosen && !go_up && !below, r_below_count == $past(r_below_count), "count moved without below-band sample")

endmodule
`default_nettype wire

/* design/fan_level_hysteresis_control_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: each sample passes the input register, then the result register,
// before its fan level request is offered.
// Throughput: one sample per cycle while the output is not stalled.
// Reset: synchronous active low; thresholds 30/40/50, margin 5, hold 60,
// no band picked yet, both pipeline registers empty.
// ----------------------------------------------------------------------------
// Fan level hysteresis control - top level
// Stream in temperature samples, stream out fan level requests.
// ----------------------------------------------------------------------------
module fan_level_hysteresis_control_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [7:0]                    i_s_tdata,   // [7:0] temp_raw
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [1:0] speed_level, [2] level_changed, [3] sensor_absent, [7:4] zero
    output logic [7:0]                         o_m_tdata,
    input  wire logic                          i_cfg_we,
    input  wire logic [flhc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [flhc_pkg::CfgDataW-1:0] i_cfg_wdata
);
    import flhc_pkg::*;

    t_cfg    cfg;
    t_result res;

    logic       r_in_valid;
    logic [7:0] r_in_temp;
    logic       r_out_valid;
    t_result    r_out_res;
    logic       fire;

    flhc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    flhc_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_temp_raw (r_in_temp),
        .i_cfg      (cfg),
        .o_res      (res)
    );

    // sample moves into the result register when that slot is free or draining
    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_temp <= i_s_tdata;
        end
        if (fire) begin
            r_out_res <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_res};

endmodule
`default_nettype wire
